// ===== rtl/core/jpath_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON path extractor package
// Shared types, result codes and error numbers.
// ----------------------------------------------------------------------------
`default_nettype none

package jpath_pkg;

  typedef enum logic [10:0] {
    M_ROOT        = 11'b000_0000_0001,
    M_KEY_WAIT    = 11'b000_0000_0010,
    M_STR         = 11'b000_0000_0100,
    M_AFTER_KEY   = 11'b000_0000_1000,
    M_AFTER_COLON = 11'b000_0001_0000,
    M_AFTER_VALUE = 11'b000_0010_0000,
    M_SKIP_PRIM   = 11'b000_0100_0000,
    M_SKIP_OBJ    = 11'b000_1000_0000,
    M_SKIP_ARR    = 11'b001_0000_0000,
    M_ARR_WAIT    = 11'b010_0000_0000,
    M_ARR_AFTER   = 11'b100_0000_0000
  } mode_e;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  localparam logic [1:0] CTX_KEY      = 2'd0;
  localparam logic [1:0] CTX_ELEM     = 2'd1;
  localparam logic [1:0] CTX_SKIP_OBJ = 2'd2;
  localparam logic [1:0] CTX_SKIP_ARR = 2'd3;

  localparam logic [3:0] E_ROOT      = 4'd0;
  localparam logic [3:0] E_KEY_MISS  = 4'd1;
  localparam logic [3:0] E_BAD_KEY   = 4'd2;
  localparam logic [3:0] E_NO_COLON  = 4'd3;
  localparam logic [3:0] E_BAD_ESC   = 4'd4;
  localparam logic [3:0] E_UNT_STR   = 4'd5;
  localparam logic [3:0] E_BAD_VAL   = 4'd6;
  localparam logic [3:0] E_UNT_CONT  = 4'd7;
  localparam logic [3:0] E_NOT_OBJ   = 4'd8;
  localparam logic [3:0] E_NOT_ARR   = 4'd9;
  localparam logic [3:0] E_NONSTR    = 4'd10;
  localparam logic [3:0] E_NO_COMMA  = 4'd11;
  localparam logic [3:0] E_UNT_ARR   = 4'd12;
  localparam logic [3:0] E_VAL_MISS  = 4'd13;

  localparam logic [2:0] REG_DEPTH = 3'd0;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] code;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/json_path_string_array_extractor.sv =====
// Results of a byte are registered and appear in the cycle after it is accepted.
// Throughput: one byte per cycle while out_stall_i is low; a byte may cause two
// results, which drain from a two-entry output queue while the input stalls.
// Reset: asynchronous active low; the walk restarts at the root, path_depth
// resets to one and all path keys to zero. The last byte also restarts the walk.
// ----------------------------------------------------------------------------
// JSON path string array extractor
// Walks a JSON byte stream along a key path and streams array string bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module json_path_string_array_extractor #(
  parameter int MAX_LEVELS = 6,
  parameter int KEY_BYTES  = 8,
  parameter int NEST_BITS  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [7:0]  doc_byte_i,
  input  wire logic        doc_last_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [1:0]  result_kind_o,
  output      logic [7:0]  out_byte_o,
  output      logic [3:0]  error_code_o,
  output      logic        run_last_o,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  localparam int KIW = $clog2(KEY_BYTES + 1);

  logic [2:0]  depth_q;
  logic [63:0] key_q [MAX_LEVELS];

  jpath_pkg::mode_e     mode_q, mode_d;
  logic [2:0]           lvl_q, lvl_d;
  logic [NEST_BITS-1:0] nest_q, nest_d;
  logic [KIW-1:0]       kidx_q, kidx_d;
  logic                 kmatch_q, kmatch_d;
  logic                 esc_q, esc_d;
  logic [1:0]           ctx_q, ctx_d;
  logic                 fin_q, fin_d;

  // Output queue, two entries.
  jpath_pkg::res_t q_res_q [2];
  logic            q_last_q [2];
  logic [1:0]      q_cnt_q;

  logic       accept;
  logic       pop;
  logic [1:0] n_res;
  jpath_pkg::res_t r0, r1;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (q_cnt_q != 2'd0) && !(q_cnt_q == 2'd1 && !out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (q_cnt_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;

  assign result_kind_o = q_res_q[0].kind;
  assign out_byte_o    = q_res_q[0].data;
  assign error_code_o  = q_res_q[0].code;
  assign run_last_o    = q_last_q[0];

  // Current key selection and length.
  logic [63:0] cur_key;
  logic [KIW-1:0] key_len;
  logic [2:0] eff_depth;
  logic       last_lvl;
  logic [7:0] key_at;

  always_comb begin
    cur_key = key_q[0];
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (lvl_q == 3'(i)) cur_key = key_q[i];
    end
    key_len = KIW'(KEY_BYTES);
    for (int i = KEY_BYTES - 1; i >= 0; i--) begin
      if (cur_key[8*i +: 8] == 8'd0) key_len = KIW'(i);
    end
    key_at = 8'd0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (kidx_q == KIW'(i)) key_at = cur_key[8*i +: 8];
    end
    if (depth_q == 3'd0) eff_depth = 3'd1;
    else if (depth_q > 3'(MAX_LEVELS)) eff_depth = 3'(MAX_LEVELS);
    else eff_depth = depth_q;
    last_lvl = ({1'b0, lvl_q} + 4'd1) >= {1'b0, eff_depth};
  end

  function automatic logic is_blank(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0b || b == 8'h0c
        || b == 8'h0d;
  endfunction

  logic [7:0] b;
  logic       emit_v;
  jpath_pkg::res_t emit_r;
  logic       fail_v;
  logic [3:0] fail_c;
  logic       dlv_v;
  logic [7:0] dlv_b;
  logic       kw_v;
  logic [3:0] end_c;

  always_comb begin
    b        = doc_byte_i;
    mode_d   = mode_q;
    lvl_d    = lvl_q;
    nest_d   = nest_q;
    kidx_d   = kidx_q;
    kmatch_d = kmatch_q;
    esc_d    = esc_q;
    ctx_d    = ctx_q;
    fin_d    = fin_q;
    emit_v   = 1'b0;
    emit_r   = '0;
    fail_v   = 1'b0;
    fail_c   = jpath_pkg::E_ROOT;
    dlv_v    = 1'b0;
    dlv_b    = b;
    kw_v     = 1'b0;
    end_c    = jpath_pkg::E_KEY_MISS;

    if (!fin_q) begin
      unique case (mode_q)
        jpath_pkg::M_ROOT: begin
          if (!is_blank(b)) begin
            if (b == "{") begin
              lvl_d  = 3'd0;
              mode_d = jpath_pkg::M_KEY_WAIT;
            end else begin
              fail_v = 1'b1;
              fail_c = jpath_pkg::E_ROOT;
            end
          end
        end
        jpath_pkg::M_KEY_WAIT: kw_v = 1'b1;
        jpath_pkg::M_STR: begin
          if (esc_q) begin
            esc_d = 1'b0;
            case (b)
              "\"", "\\", "/": dlv_v = 1'b1;
              "b": begin dlv_v = 1'b1; dlv_b = 8'd8;  end
              "f": begin dlv_v = 1'b1; dlv_b = 8'd12; end
              "n": begin dlv_v = 1'b1; dlv_b = 8'd10; end
              "r": begin dlv_v = 1'b1; dlv_b = 8'd13; end
              "t": begin dlv_v = 1'b1; dlv_b = 8'd9;  end
              default: begin
                fail_v = 1'b1;
                fail_c = jpath_pkg::E_BAD_ESC;
              end
            endcase
          end else if (b == "\"") begin
            if (ctx_q == jpath_pkg::CTX_KEY) begin
              if (kidx_q != key_len) kmatch_d = 1'b0;
              mode_d = jpath_pkg::M_AFTER_KEY;
            end else if (ctx_q == jpath_pkg::CTX_ELEM) begin
              emit_v      = 1'b1;
              emit_r.kind = jpath_pkg::KIND_END;
              mode_d      = jpath_pkg::M_ARR_AFTER;
            end else if (nest_q == '0) begin
              mode_d = jpath_pkg::M_AFTER_VALUE;
            end else begin
              mode_d = (ctx_q == jpath_pkg::CTX_SKIP_OBJ) ? jpath_pkg::M_SKIP_OBJ
                                                          : jpath_pkg::M_SKIP_ARR;
            end
          end else if (b == "\\") begin
            esc_d = 1'b1;
          end else begin
            dlv_v = 1'b1;
          end
        end
        jpath_pkg::M_AFTER_KEY: begin
          if (!is_blank(b)) begin
            if (b == ":") mode_d = jpath_pkg::M_AFTER_COLON;
            else begin
              fail_v = 1'b1;
              fail_c = jpath_pkg::E_NO_COLON;
            end
          end
        end
        jpath_pkg::M_AFTER_COLON: begin
          if (!is_blank(b)) begin
            if (kmatch_q) begin
              if (last_lvl) begin
                if (b == "[") mode_d = jpath_pkg::M_ARR_WAIT;
                else begin
                  fail_v = 1'b1;
                  fail_c = jpath_pkg::E_NOT_ARR;
                end
              end else if (b == "{") begin
                lvl_d  = lvl_q + 3'd1;
                mode_d = jpath_pkg::M_KEY_WAIT;
              end else begin
                fail_v = 1'b1;
                fail_c = jpath_pkg::E_NOT_OBJ;
              end
            end else begin
              nest_d = '0;
              if (b == "\"") begin
                mode_d = jpath_pkg::M_STR;
                ctx_d  = jpath_pkg::CTX_SKIP_OBJ;
                esc_d  = 1'b0;
              end else if (b == "{") begin
                nest_d = NEST_BITS'(1);
                mode_d = jpath_pkg::M_SKIP_OBJ;
              end else if (b == "[") begin
                nest_d = NEST_BITS'(1);
                mode_d = jpath_pkg::M_SKIP_ARR;
              end else if (b == "t" || b == "f" || b == "n" || b == "-" ||
                           (b >= "0" && b <= "9")) begin
                mode_d = jpath_pkg::M_SKIP_PRIM;
              end else begin
                fail_v = 1'b1;
                fail_c = jpath_pkg::E_BAD_VAL;
              end
            end
          end
        end
        jpath_pkg::M_AFTER_VALUE: begin
          if (b == ",") mode_d = jpath_pkg::M_KEY_WAIT;
          else kw_v = 1'b1;
        end
        jpath_pkg::M_SKIP_PRIM: begin
          if (is_blank(b) || b == "," || b == "}" || b == "]") begin
            mode_d = jpath_pkg::M_AFTER_VALUE;
            if (b == ",") mode_d = jpath_pkg::M_KEY_WAIT;
            else kw_v = 1'b1;
          end
        end
        jpath_pkg::M_SKIP_OBJ, jpath_pkg::M_SKIP_ARR: begin
          if (b == "\"") begin
            mode_d = jpath_pkg::M_STR;
            esc_d  = 1'b0;
            ctx_d  = (mode_q == jpath_pkg::M_SKIP_OBJ) ? jpath_pkg::CTX_SKIP_OBJ
                                                       : jpath_pkg::CTX_SKIP_ARR;
          end else if ((mode_q == jpath_pkg::M_SKIP_OBJ && b == "{") ||
                       (mode_q == jpath_pkg::M_SKIP_ARR && b == "[")) begin
            if (&nest_q) begin
              fail_v = 1'b1;
              fail_c = jpath_pkg::E_UNT_CONT;
            end else nest_d = nest_q + NEST_BITS'(1);
          end else if ((mode_q == jpath_pkg::M_SKIP_OBJ && b == "}") ||
                       (mode_q == jpath_pkg::M_SKIP_ARR && b == "]")) begin
            // A close with the count at zero or one ends the skipped value.
            if (nest_q != '0) nest_d = nest_q - NEST_BITS'(1);
            if (nest_q <= NEST_BITS'(1)) mode_d = jpath_pkg::M_AFTER_VALUE;
          end
        end
        jpath_pkg::M_ARR_WAIT: begin
          if (!is_blank(b)) begin
            if (b == "]") begin
              emit_v      = 1'b1;
              emit_r.kind = jpath_pkg::KIND_DONE;
              fin_d       = 1'b1;
            end else if (b == "\"") begin
              mode_d = jpath_pkg::M_STR;
              ctx_d  = jpath_pkg::CTX_ELEM;
              esc_d  = 1'b0;
            end else begin
              fail_v = 1'b1;
              fail_c = jpath_pkg::E_NONSTR;
            end
          end
        end
        jpath_pkg::M_ARR_AFTER: begin
          if (!is_blank(b)) begin
            if (b == ",") mode_d = jpath_pkg::M_ARR_WAIT;
            else if (b == "]") begin
              emit_v      = 1'b1;
              emit_r.kind = jpath_pkg::KIND_DONE;
              fin_d       = 1'b1;
            end else begin
              fail_v = 1'b1;
              fail_c = jpath_pkg::E_NO_COMMA;
            end
          end
        end
        default: begin
          fail_v = 1'b1;
          fail_c = jpath_pkg::E_ROOT;
        end
      endcase

      if (kw_v && !is_blank(b)) begin
        if (b == "}") begin
          fail_v = 1'b1;
          fail_c = jpath_pkg::E_KEY_MISS;
        end else if (b == "\"") begin
          mode_d   = jpath_pkg::M_STR;
          ctx_d    = jpath_pkg::CTX_KEY;
          esc_d    = 1'b0;
          kidx_d   = '0;
          kmatch_d = 1'b1;
        end else begin
          fail_v = 1'b1;
          fail_c = jpath_pkg::E_BAD_KEY;
        end
      end

      if (dlv_v) begin
        if (ctx_q == jpath_pkg::CTX_KEY) begin
          if (kmatch_q && kidx_q < key_len && key_at == dlv_b)
            kidx_d = kidx_q + KIW'(1);
          else kmatch_d = 1'b0;
        end else if (ctx_q == jpath_pkg::CTX_ELEM) begin
          emit_v      = 1'b1;
          emit_r.kind = jpath_pkg::KIND_BYTE;
          emit_r.data = dlv_b;
        end
      end

      if (fail_v) begin
        emit_v      = 1'b1;
        emit_r.kind = jpath_pkg::KIND_ERR;
        emit_r.data = 8'd0;
        emit_r.code = fail_c;
        fin_d       = 1'b1;
      end

      // End-of-document error for the state left by this byte.
      case (mode_d)
        jpath_pkg::M_ROOT:        end_c = jpath_pkg::E_ROOT;
        jpath_pkg::M_STR:         end_c = jpath_pkg::E_UNT_STR;
        jpath_pkg::M_AFTER_KEY:   end_c = jpath_pkg::E_NO_COLON;
        jpath_pkg::M_AFTER_COLON:
          end_c = !kmatch_d ? jpath_pkg::E_VAL_MISS
                : (last_lvl ? jpath_pkg::E_NOT_ARR : jpath_pkg::E_NOT_OBJ);
        jpath_pkg::M_SKIP_OBJ, jpath_pkg::M_SKIP_ARR: end_c = jpath_pkg::E_UNT_CONT;
        jpath_pkg::M_ARR_WAIT, jpath_pkg::M_ARR_AFTER: end_c = jpath_pkg::E_UNT_ARR;
        default:                  end_c = jpath_pkg::E_KEY_MISS;
      endcase
    end
  end

  // Assemble up to two results for this item.
  logic end_err;
  always_comb begin
    end_err = doc_last_i && !fin_q && !fin_d;
    r0 = emit_r;
    r1 = '0;
    n_res = 2'd0;
    if (emit_v) begin
      n_res = 2'd1;
      if (end_err) begin
        r1.kind = jpath_pkg::KIND_ERR;
        r1.code = end_c;
        n_res   = 2'd2;
      end
    end else if (end_err) begin
      r0      = '0;
      r0.kind = jpath_pkg::KIND_ERR;
      r0.code = end_c;
      n_res   = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= 3'd1;
      for (int i = 0; i < MAX_LEVELS; i++) key_q[i] <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == jpath_pkg::REG_DEPTH) depth_q <= cfg_data_i[2:0];
      for (int i = 0; i < MAX_LEVELS; i++) begin
        if (cfg_index_i == 3'(i + 1)) key_q[i] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= jpath_pkg::M_ROOT;
      lvl_q    <= '0;
      nest_q   <= '0;
      kidx_q   <= '0;
      kmatch_q <= 1'b1;
      esc_q    <= 1'b0;
      ctx_q    <= '0;
      fin_q    <= 1'b0;
    end else if (accept) begin
      if (doc_last_i) begin
        mode_q   <= jpath_pkg::M_ROOT;
        lvl_q    <= '0;
        nest_q   <= '0;
        kidx_q   <= '0;
        kmatch_q <= 1'b1;
        esc_q    <= 1'b0;
        ctx_q    <= '0;
        fin_q    <= 1'b0;
      end else begin
        mode_q   <= mode_d;
        lvl_q    <= lvl_d;
        nest_q   <= nest_d;
        kidx_q   <= kidx_d;
        kmatch_q <= kmatch_d;
        esc_q    <= esc_d;
        ctx_q    <= ctx_d;
        fin_q    <= fin_d;
      end
    end
  end

  // The queue is empty or about to drain whenever an item is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q <= 2'd0;
    end else if (accept) begin
      q_cnt_q <= n_res;
    end else if (pop) begin
      q_cnt_q <= q_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_res_q[0]  <= r0;
      q_last_q[0] <= (n_res == 2'd1);
      q_res_q[1]  <= r1;
      q_last_q[1] <= 1'b1;
    end else if (pop) begin
      q_res_q[0]  <= q_res_q[1];
      q_last_q[0] <= q_last_q[1];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (q_cnt_q == 2'd0) || (q_cnt_q == 2'd1 && pop))
    else $error("item accepted while results still queued");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q != 2'd3)
    else $error("output queue overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_cnt_q == 2'd2) |-> !q_last_q[0])
    else $error("first of two results marked last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && doc_last_i) |=> !fin_q && mode_q == jpath_pkg::M_ROOT)
    else $error("walk not restarted after last byte");

endmodule

`default_nettype wire

// ===== sim/tb_json_path_string_array_extractor.sv =====
// ----------------------------------------------------------------------------
// JSON path string array extractor testbench
// Feeds generated JSON documents, mostly well formed along the configured
// path and some broken or pure noise, under several path settings. A
// scoreboard predicts every result item and checks the block's output.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_json_path_string_array_extractor;

  localparam logic [2:0] REG_KEY0 = 3'd1;
  localparam int NEST_TOP = 65535;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    jpath_pkg::res_t r;
    logic last;
  } out_item_t;

  class ExtractScoreboard;
    logic [2:0] depth;
    logic [63:0] keys [6];
    jpath_pkg::mode_e mode;
    int unsigned level, nest, kidx;
    bit kmatch, esc, done;
    logic [1:0] ctx;
    out_item_t step_q[$];
    out_item_t want_q[$];
    int mism, checked;

    function void clear_walk();
      mode = jpath_pkg::M_ROOT; level = 0; nest = 0; kidx = 0;
      kmatch = 1; esc = 0; ctx = jpath_pkg::CTX_KEY; done = 0;
    endfunction

    function new();
      depth = 3'd1;
      foreach (keys[i]) keys[i] = '0;
      clear_walk();
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
      if (idx == jpath_pkg::REG_DEPTH) depth = val[2:0];
      else if (idx <= 3'd6) keys[idx - 1] = val;
    endfunction

    function void emit(logic [1:0] kind, logic [7:0] data, logic [3:0] code);
      out_item_t o;
      if (step_q.size() >= 2) return;
      o.r.kind = kind; o.r.data = data; o.r.code = code; o.last = 0;
      step_q.insert(step_q.size(), o);
    endfunction

    function void fail(logic [3:0] code);
      emit(jpath_pkg::KIND_ERR, 8'd0, code);
      done = 1;
    endfunction

    function bit blank(logic [7:0] b);
      return b == " " || b == 8'd9 || b == 8'd10 || b == 8'd11 || b == 8'd12 || b == 8'd13;
    endfunction

    function int unsigned eff_depth();
      if (depth < 1) return 1;
      if (depth > 6) return 6;
      return 32'(depth);
    endfunction

    function logic [7:0] key_byte(int unsigned i);
      logic [63:0] k;
      k = keys[level % 6];
      return k[8*i +: 8];
    endfunction

    function int unsigned key_len();
      for (int i = 0; i < 8; i++) if (key_byte(i) == 0) return i;
      return 8;
    endfunction

    function bit last_level();
      return level + 1 >= eff_depth();
    endfunction

    function void start_string(logic [1:0] c);
      mode = jpath_pkg::M_STR; ctx = c; esc = 0;
      if (c == jpath_pkg::CTX_KEY) begin
        kidx = 0; kmatch = 1;
      end
    endfunction

    function void deliver(logic [7:0] d);
      if (ctx == jpath_pkg::CTX_KEY) begin
        if (kmatch && kidx < key_len() && key_byte(kidx) == d) kidx++;
        else kmatch = 0;
      end else if (ctx == jpath_pkg::CTX_ELEM) begin
        emit(jpath_pkg::KIND_BYTE, d, 4'd0);
      end
    endfunction

    function void close_string();
      if (ctx == jpath_pkg::CTX_KEY) begin
        if (kidx != key_len()) kmatch = 0;
        mode = jpath_pkg::M_AFTER_KEY;
      end else if (ctx == jpath_pkg::CTX_ELEM) begin
        emit(jpath_pkg::KIND_END, 8'd0, 4'd0);
        mode = jpath_pkg::M_ARR_AFTER;
      end else if (nest == 0) begin
        mode = jpath_pkg::M_AFTER_VALUE;
      end else begin
        mode = (ctx == jpath_pkg::CTX_SKIP_OBJ) ? jpath_pkg::M_SKIP_OBJ
                                                 : jpath_pkg::M_SKIP_ARR;
      end
    endfunction

    function void string_byte(logic [7:0] b);
      if (esc) begin
        esc = 0;
        case (b)
          "\"", "\\", "/": deliver(b);
          "b": deliver(8'd8);
          "f": deliver(8'd12);
          "n": deliver(8'd10);
          "r": deliver(8'd13);
          "t": deliver(8'd9);
          default: fail(jpath_pkg::E_BAD_ESC);
        endcase
      end else if (b == "\"") begin
        close_string();
      end else if (b == "\\") begin
        esc = 1;
      end else begin
        deliver(b);
      end
    endfunction

    function void key_wait(logic [7:0] b);
      if (blank(b)) return;
      if (b == "}") fail(jpath_pkg::E_KEY_MISS);
      else if (b == "\"") start_string(jpath_pkg::CTX_KEY);
      else fail(jpath_pkg::E_BAD_KEY);
    endfunction

    function void skip_nest(logic [7:0] b, logic [7:0] open, logic [7:0] shut,
                            logic [1:0] c);
      if (b == "\"") begin
        start_string(c);
      end else if (b == open) begin
        if (nest >= NEST_TOP) fail(jpath_pkg::E_UNT_CONT);
        else nest++;
      end else if (b == shut) begin
        if (nest > 0) nest--;
        if (nest == 0) mode = jpath_pkg::M_AFTER_VALUE;
      end
    endfunction

    function void after_colon(logic [7:0] b);
      if (blank(b)) return;
      if (kmatch) begin
        if (last_level()) begin
          if (b == "[") mode = jpath_pkg::M_ARR_WAIT;
          else fail(jpath_pkg::E_NOT_ARR);
        end else if (b == "{") begin
          level++;
          mode = jpath_pkg::M_KEY_WAIT;
        end else begin
          fail(jpath_pkg::E_NOT_OBJ);
        end
        return;
      end
      nest = 0;
      if (b == "\"") start_string(jpath_pkg::CTX_SKIP_OBJ);
      else if (b == "{") begin
        nest = 1; mode = jpath_pkg::M_SKIP_OBJ;
      end else if (b == "[") begin
        nest = 1; mode = jpath_pkg::M_SKIP_ARR;
      end else if (b == "t" || b == "f" || b == "n" || b == "-" || (b >= "0" && b <= "9"))
        mode = jpath_pkg::M_SKIP_PRIM;
      else fail(jpath_pkg::E_BAD_VAL);
    endfunction

    function void walk(logic [7:0] b);
      case (mode)
        jpath_pkg::M_ROOT: begin
          if (blank(b)) return;
          if (b == "{") begin
            level = 0; mode = jpath_pkg::M_KEY_WAIT;
          end else fail(jpath_pkg::E_ROOT);
        end
        jpath_pkg::M_KEY_WAIT: key_wait(b);
        jpath_pkg::M_STR: string_byte(b);
        jpath_pkg::M_AFTER_KEY: begin
          if (blank(b)) return;
          if (b == ":") mode = jpath_pkg::M_AFTER_COLON;
          else fail(jpath_pkg::E_NO_COLON);
        end
        jpath_pkg::M_AFTER_COLON: after_colon(b);
        jpath_pkg::M_AFTER_VALUE: begin
          if (b == ",") mode = jpath_pkg::M_KEY_WAIT;
          else key_wait(b);
        end
        jpath_pkg::M_SKIP_PRIM: begin
          // The byte that ends a primitive is parsed again as after a value.
          if (blank(b) || b == "," || b == "}" || b == "]") begin
            mode = jpath_pkg::M_AFTER_VALUE;
            if (b == ",") mode = jpath_pkg::M_KEY_WAIT;
            else key_wait(b);
          end
        end
        jpath_pkg::M_SKIP_OBJ: skip_nest(b, "{", "}", jpath_pkg::CTX_SKIP_OBJ);
        jpath_pkg::M_SKIP_ARR: skip_nest(b, "[", "]", jpath_pkg::CTX_SKIP_ARR);
        jpath_pkg::M_ARR_WAIT: begin
          if (blank(b)) return;
          if (b == "]") begin
            emit(jpath_pkg::KIND_DONE, 8'd0, 4'd0); done = 1;
          end else if (b == "\"") start_string(jpath_pkg::CTX_ELEM);
          else fail(jpath_pkg::E_NONSTR);
        end
        jpath_pkg::M_ARR_AFTER: begin
          if (blank(b)) return;
          if (b == ",") mode = jpath_pkg::M_ARR_WAIT;
          else if (b == "]") begin
            emit(jpath_pkg::KIND_DONE, 8'd0, 4'd0); done = 1;
          end else fail(jpath_pkg::E_NO_COMMA);
        end
        default: fail(jpath_pkg::E_ROOT);
      endcase
    endfunction

    function logic [3:0] end_code();
      case (mode)
        jpath_pkg::M_ROOT: return jpath_pkg::E_ROOT;
        jpath_pkg::M_STR: return jpath_pkg::E_UNT_STR;
        jpath_pkg::M_AFTER_KEY: return jpath_pkg::E_NO_COLON;
        jpath_pkg::M_AFTER_COLON: begin
          if (!kmatch) return jpath_pkg::E_VAL_MISS;
          return last_level() ? jpath_pkg::E_NOT_ARR : jpath_pkg::E_NOT_OBJ;
        end
        jpath_pkg::M_SKIP_OBJ, jpath_pkg::M_SKIP_ARR: return jpath_pkg::E_UNT_CONT;
        jpath_pkg::M_ARR_WAIT, jpath_pkg::M_ARR_AFTER: return jpath_pkg::E_UNT_ARR;
        default: return jpath_pkg::E_KEY_MISS;
      endcase
    endfunction

    // Predicts the results of one accepted document byte.
    function void note_byte(logic [7:0] b, logic last);
      step_q.delete();
      if (!done) begin
        walk(b);
        if (last && !done) fail(end_code());
      end
      if (last) clear_walk();
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1;
      foreach (step_q[i]) want_q.insert(want_q.size(), step_q[i]);
    endfunction

    function void report(string what, out_item_t w, out_item_t got);
      mism++;
      if (mism <= 10)
        $display({"MISMATCH %s: expected kind %0d byte %02h code %0d last %0d,",
                  " got kind %0d byte %02h code %0d last %0d"},
                 what, w.r.kind, w.r.data, w.r.code, w.last,
                 got.r.kind, got.r.data, got.r.code, got.last);
    endfunction

    function void check_result(out_item_t got);
      out_item_t w;
      checked++;
      if (want_q.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      w = want_q.pop_front();
      if (w.r.kind != got.r.kind) report("result_kind", w, got);
      else if (w.r.data != got.r.data) report("out_byte", w, got);
      else if (w.r.code != got.r.code) report("error_code", w, got);
      else if (w.last != got.last) report("run_last", w, got);
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic [7:0] doc_byte_i = '0;
  logic doc_last_i = 0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic [1:0] result_kind_o;
  logic [7:0] out_byte_o;
  logic [3:0] error_code_o;
  logic run_last_o;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  json_path_string_array_extractor dut (.*);

  ExtractScoreboard sb = new();
  logic [7:0] doc_q[$];
  logic [63:0] path_keys[6];
  int path_len;
  bit idling = 1;
  int cycles, n_docs, n_bytes, stall_left, free_left;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_json_path_string_array_extractor: done, errors");
      $finish;
    end
  end

  // Result side: check accepted items and, while idling is set, stall in random bursts.
  always @(posedge clk_i) begin
    out_item_t got;
    if (out_valid_o && !out_stall_i && rst_ni) begin
      got.r.kind = result_kind_o; got.r.data = out_byte_o;
      got.r.code = error_code_o; got.last = run_last_o;
      sb.check_result(got);
    end
    if (!idling || !rst_ni) begin
      out_stall_i <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1;
    end else if (free_left > 0) begin
      free_left <= free_left - 1;
      out_stall_i <= 0;
    end else begin
      if ($urandom_range(0, 1)) stall_left <= $urandom_range(1, 16);
      free_left <= $urandom_range(1, 30);
      out_stall_i <= 0;
    end
  end

  function automatic void add_byte(logic [7:0] c);
    doc_q.insert(doc_q.size(), c);
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    doc_byte_i <= b;
    doc_last_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b, last);
    n_bytes++;
  endtask

  task automatic send_doc();
    foreach (doc_q[i]) send_byte(doc_q[i], i == doc_q.size() - 1);
    n_docs++;
  endtask

  task automatic send_text(string s);
    doc_q.delete();
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    send_doc();
  endtask

  // Lets the block drain completely so that a register write finds it idle.
  task automatic drain();
    in_valid_i <= 0;
    while (sb.want_q.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
  endtask

  task automatic set_path(int d);
    write_reg(jpath_pkg::REG_DEPTH, 64'(d));
    for (int i = 0; i < 6; i++) write_reg(REG_KEY0 + 3'(i), path_keys[i]);
    cfg_valid_i <= 0;
    path_len = d;
  endtask

  function automatic logic [63:0] rand_key(bit full_len);
    logic [63:0] k;
    string alpha;
    int n;
    alpha = "ab/\"\\\n\tz";
    k = '0;
    n = full_len ? 8 : $urandom_range(0, 8);
    for (int i = 0; i < n; i++)
      k[8*i +: 8] = $urandom_range(0, 1) ? alpha[$urandom_range(0, alpha.len() - 1)]
                                         : 8'($urandom_range(1, 255));
    return k;
  endfunction

  function automatic void put_blanks();
    logic [7:0] sp[6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
    repeat ($urandom_range(0, 2)) add_byte(sp[$urandom_range(0, 5)]);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // Writes one byte inside a JSON string, escaped where it must or may be.
  function automatic void put_char(logic [7:0] c);
    bit esc_it;
    esc_it = $urandom_range(0, 1);
    case (c)
      "\"", "\\": begin
        add_byte("\\"); add_byte(c);
      end
      "/": begin
        if (esc_it) add_byte("\\");
        add_byte(c);
      end
      8'd8: if (esc_it) put_text("\\b"); else add_byte(c);
      8'd12: if (esc_it) put_text("\\f"); else add_byte(c);
      8'd10: if (esc_it) put_text("\\n"); else add_byte(c);
      8'd13: if (esc_it) put_text("\\r"); else add_byte(c);
      8'd9: if (esc_it) put_text("\\t"); else add_byte(c);
      default: add_byte(c);
    endcase
  endfunction

  function automatic void put_key(logic [63:0] k);
    add_byte("\"");
    for (int i = 0; i < 8 && k[8*i +: 8] != 0; i++) put_char(k[8*i +: 8]);
    add_byte("\"");
  endfunction

  function automatic void put_string(int n);
    add_byte("\"");
    repeat (n) put_char(8'($urandom_range(0, 255)));
    add_byte("\"");
  endfunction

  function automatic void put_value(int lvl);
    string prims[5] = '{"true", "false", "null", "-3.5", "42"};
    int sel;
    sel = (lvl > 0) ? $urandom_range(0, 3) : $urandom_range(0, 1);
    case (sel)
      0: put_string($urandom_range(0, 4));
      1: put_text(prims[$urandom_range(0, 4)]);
      2: begin
        add_byte("{");
        repeat ($urandom_range(0, 2)) begin
          put_blanks(); put_key(rand_key(0)); add_byte(":");
          put_blanks(); put_value(lvl - 1); add_byte(",");
        end
        add_byte("}");
      end
      default: begin
        add_byte("[");
        repeat ($urandom_range(0, 3)) begin
          put_value(lvl - 1); add_byte(",");
        end
        add_byte("]");
      end
    endcase
  endfunction

  function automatic void put_array();
    int n;
    n = $urandom_range(0, 3);
    add_byte("[");
    for (int i = 0; i < n; i++) begin
      put_blanks();
      put_string($urandom_range(0, 6));
      put_blanks();
      if (i < n - 1 || $urandom_range(0, 3) == 0) add_byte(",");
    end
    put_blanks();
    add_byte("]");
  endfunction

  // Builds a document that follows the configured path and maybe breaks it, or pure noise.
  function automatic void build_doc();
    int pick, cut;
    doc_q.delete();
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    put_blanks();
    for (int lv = 0; lv < path_len; lv++) begin
      add_byte("{");
      repeat ($urandom_range(0, 2)) begin
        put_blanks(); put_key(rand_key(0)); put_blanks(); add_byte(":");
        put_blanks(); put_value(2); add_byte(",");
      end
      put_blanks(); put_key(path_keys[lv]); put_blanks(); add_byte(":");
      put_blanks();
      if (lv == path_len - 1) put_array();
    end
    for (int lv = 0; lv < path_len; lv++) begin
      put_blanks(); add_byte("}");
    end
    if (pick == 1 || pick == 2) begin
      doc_q[$urandom_range(0, doc_q.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (pick == 3) begin
      cut = $urandom_range(1, doc_q.size());
      while (doc_q.size() > cut) void'(doc_q.pop_back());
    end
  endfunction

  initial begin
    int phase_bytes;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Reset path: one level, empty key.
    send_text("x");
    send_text("{}");
    send_text("{1");
    send_text("{\"\" 5");
    send_text("{\"\":[\"\\u");
    send_text("{\"\":[\"a\\n");
    send_text("{\"q\":@");
    send_text("{\"q\":1]");
    send_text("{\"\":5");
    send_text("{\"\":[7");
    send_text("{\"\":[\"\" \"\"");
    send_text("{\"\":[\"x\",]} tail");
    send_text("{\"q\":[[\"]\"]],\"\":[]}");
    send_text("{\"q\":{\"");
    send_text("{\"q\":");
    send_text("{\"\":");

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      for (int i = 0; i < 6; i++) path_keys[i] = rand_key(ph == 2);
      if (ph == 3) foreach (path_keys[i]) path_keys[i] = '0;
      if (ph == 4) idling = 0;
      set_path(ph == 0 ? 1 : ph == 1 ? 6 : $urandom_range(1, 3));
      phase_bytes = 0;
      while (phase_bytes < 40) begin
        build_doc();
        phase_bytes += doc_q.size();
        send_doc();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.want_q.size() > 0) begin
      sb.mism++;
      $display("%0d expected results never arrived", sb.want_q.size());
    end
    $display("Sent %0d documents (%0d bytes) over 1 to 6 path levels; checked %0d results.",
             n_docs, n_bytes, sb.checked);
    $display("Mismatches: %0d", sb.mism);
    if (sb.mism == 0) begin
      $display("tb_json_path_string_array_extractor: done, clean");
    end else begin
      $display("tb_json_path_string_array_extractor: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/jpath_pkg.sv
rtl/core/json_path_string_array_extractor.sv
sim/tb_json_path_string_array_extractor.sv
